// ===== sv/fsic_pkg.sv =====
// ============================================================================
// fsic_pkg - shared types, constants and tables of the fan speed controller
// Holds the microcode program, the set point table and the datapath widths.
// ============================================================================
package fsic_pkg;

  // Design constants
  localparam int SET_POINT_COUNT = 12;
  localparam int INTEGRATOR_BITS = 24;

  localparam int SP_SLOTS = 16;
  localparam int SP_IDX_W = 4;
  localparam int SP_W     = 13;
  localparam int SPEED_W  = 16;
  localparam int CYC_W    = 7;
  localparam int CAP_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int SCALE_W  = 27;
  localparam int PULSE_W  = 8;
  localparam int CFG_W    = 27;
  localparam int CFG_IDX_W = 1;

  localparam int DIVIDEND_W = SCALE_W + CYC_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
  localparam int ERR_W      = SPEED_W + 1;
  localparam int PROD_W     = GAIN_W + 1 + ERR_W;
  localparam int ACC_W      = ((INTEGRATOR_BITS + 1 > PROD_W) ?
                               (INTEGRATOR_BITS + 1) : PROD_W) + 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [INTEGRATOR_BITS-1:0] INTEG_RESET =
    INTEGRATOR_BITS'(128) << (INTEGRATOR_BITS - PULSE_W);
  localparam logic [SP_IDX_W-1:0] SP_IDX_RESET = SP_IDX_W'(1);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(1000);
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(90000000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = CFG_IDX_W'(1);

  // Microcode
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE  = STEP_W'(0);
  localparam step_t ST_INIT  = STEP_W'(1);
  localparam step_t ST_CHECK = STEP_W'(2);
  localparam step_t ST_DIV   = STEP_W'(3);
  localparam step_t ST_SPEED = STEP_W'(4);
  localparam step_t ST_GAIN  = STEP_W'(5);
  localparam step_t ST_ACCUM = STEP_W'(6);
  localparam step_t ST_BTN   = STEP_W'(7);
  localparam step_t ST_FLT   = STEP_W'(8);
  localparam step_t ST_DONE  = STEP_W'(9);
  localparam step_t ST_RET   = STEP_W'(10);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_DIV,
    OP_SPEED,
    OP_GAIN,
    OP_ACCUM,
    OP_NEXT_SP,
    OP_FAULT
  } dp_op_e;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NO_START,
    JMP_BUTTON,
    JMP_FAULT,
    JMP_DIV_MORE,
    JMP_OUT_BUSY
  } jmp_e;

  typedef struct packed {
    dp_op_e op;
    jmp_e   jmp;
    step_t  target;
    logic   emit;
  } ucode_t;

  typedef struct packed {
    dp_op_e op;
    logic   emit;
  } dp_ctrl_t;

  typedef struct packed {
    logic button;
    logic fault;
    logic div_more;
  } dp_status_t;

  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    w = '{op: OP_NOP, jmp: JMP_ALWAYS, target: ST_IDLE, emit: 1'b0};
    unique case (step)
      ST_IDLE:  w = '{op: OP_NOP,     jmp: JMP_NO_START, target: ST_IDLE, emit: 1'b0};
      ST_INIT:  w = '{op: OP_INIT,    jmp: JMP_BUTTON,   target: ST_BTN,  emit: 1'b0};
      ST_CHECK: w = '{op: OP_NOP,     jmp: JMP_FAULT,    target: ST_FLT,  emit: 1'b0};
      ST_DIV:   w = '{op: OP_DIV,     jmp: JMP_DIV_MORE, target: ST_DIV,  emit: 1'b0};
      ST_SPEED: w = '{op: OP_SPEED,   jmp: JMP_NONE,     target: ST_IDLE, emit: 1'b0};
      ST_GAIN:  w = '{op: OP_GAIN,    jmp: JMP_NONE,     target: ST_IDLE, emit: 1'b0};
      ST_ACCUM: w = '{op: OP_ACCUM,   jmp: JMP_ALWAYS,   target: ST_DONE, emit: 1'b0};
      ST_BTN:   w = '{op: OP_NEXT_SP, jmp: JMP_ALWAYS,   target: ST_DONE, emit: 1'b0};
      ST_FLT:   w = '{op: OP_FAULT,   jmp: JMP_NONE,     target: ST_IDLE, emit: 1'b0};
      ST_DONE:  w = '{op: OP_NOP,     jmp: JMP_OUT_BUSY, target: ST_DONE, emit: 1'b1};
      ST_RET:   w = '{op: OP_NOP,     jmp: JMP_ALWAYS,   target: ST_IDLE, emit: 1'b0};
      default:  w = '{op: OP_NOP,     jmp: JMP_ALWAYS,   target: ST_IDLE, emit: 1'b0};
    endcase
    return w;
  endfunction

  // Set point table; unused slots read zero
  function automatic logic [SP_W-1:0] set_point_rom(logic [SP_IDX_W-1:0] idx);
    logic [SP_W-1:0] v;
    v = '0;
    case (idx)
      4'd0:    v = SP_W'(2000);
      4'd1:    v = SP_W'(3000);
      4'd2:    v = SP_W'(4000);
      4'd3:    v = SP_W'(5000);
      4'd4:    v = SP_W'(6000);
      4'd5:    v = SP_W'(7000);
      4'd6:    v = SP_W'(8000);
      4'd7:    v = SP_W'(7000);
      4'd8:    v = SP_W'(6000);
      4'd9:    v = SP_W'(5000);
      4'd10:   v = SP_W'(4000);
      4'd11:   v = SP_W'(3000);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/fsic_seq.sv =====
// ============================================================================
// fsic_seq - microcode sequencer
// Step counter over the control program with conditional jumps.
// ============================================================================
module fsic_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  out_busy_i,
  input  fsic_pkg::dp_status_t  status_i,
  output fsic_pkg::dp_ctrl_t    ctrl_o,
  output logic                  idle_o
);

  fsic_pkg::step_t  step_q, step_d;
  fsic_pkg::ucode_t word;
  logic             take;

  always_comb begin
    word = fsic_pkg::ucode_rom(step_q);
    unique case (word.jmp)
      fsic_pkg::JMP_NONE:     take = 1'b0;
      fsic_pkg::JMP_ALWAYS:   take = 1'b1;
      fsic_pkg::JMP_NO_START: take = !start_i;
      fsic_pkg::JMP_BUTTON:   take = status_i.button;
      fsic_pkg::JMP_FAULT:    take = status_i.fault;
      fsic_pkg::JMP_DIV_MORE: take = status_i.div_more;
      fsic_pkg::JMP_OUT_BUSY: take = out_busy_i;
      default:                take = 1'b1;
    endcase
    step_d = take ? word.target : step_q + fsic_pkg::STEP_W'(1);
    ctrl_o.op   = word.op;
    // emit only on the pass that leaves the done step
    ctrl_o.emit = word.emit && !out_busy_i;
    idle_o      = (step_q == fsic_pkg::ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= fsic_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== sv/fsic_dp.sv =====
// ============================================================================
// fsic_dp - controller datapath
// Input latch, serial divider, gain multiplier, clamped integrator and
// set point index; all but the latch follow the current control word.
// ============================================================================
module fsic_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fsic_pkg::dp_ctrl_t                     ctrl_i,
  input  logic                                   load_i,
  input  logic                                   func_i,
  input  logic [fsic_pkg::CYC_W-1:0]             num_cycles_i,
  input  logic [fsic_pkg::CAP_W-1:0]             first_capture_i,
  input  logic [fsic_pkg::CAP_W-1:0]             last_capture_i,
  input  logic [fsic_pkg::GAIN_W-1:0]            gain_i,
  input  logic [fsic_pkg::SCALE_W-1:0]           scale_i,
  output fsic_pkg::dp_status_t                   status_o,
  output logic [fsic_pkg::PULSE_W-1:0]           pulse_width_o,
  output logic [fsic_pkg::SPEED_W-1:0]           speed_rpm_o,
  output logic [fsic_pkg::SP_W-1:0]              set_point_rpm_o,
  output logic                                   period_fault_o
);

  localparam int IB  = fsic_pkg::INTEGRATOR_BITS;
  localparam int DW  = fsic_pkg::DIVIDEND_W;
  localparam int SW  = fsic_pkg::SPEED_W;
  localparam int CW  = fsic_pkg::CAP_W;
  localparam int AW  = fsic_pkg::ACC_W;

  logic                                button_q;
  logic [fsic_pkg::CYC_W-1:0]          cycles_q;
  logic [CW-1:0]                       diff_q;
  logic                                fault_q;
  logic [DW-1:0]                       quo_q;
  logic [CW-1:0]                       rem_q;
  logic [fsic_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [SW-1:0]                       speed_q;
  logic signed [fsic_pkg::ERR_W-1:0]   err_q;
  logic signed [fsic_pkg::PROD_W-1:0]  prod_q;
  logic [IB-1:0]                       integ_q;
  logic [fsic_pkg::SP_IDX_W-1:0]       sp_idx_q;

  logic [CW:0]                         trial;
  logic                                ge;
  logic [SW-1:0]                       speed_sat;
  logic [fsic_pkg::SP_W-1:0]           set_point;
  logic signed [fsic_pkg::ERR_W-1:0]   err_nxt;
  logic signed [fsic_pkg::PROD_W-1:0]  prod_nxt;
  logic signed [AW-1:0]                sum;
  logic [IB-1:0]                       integ_nxt;
  logic [fsic_pkg::SP_IDX_W:0]         sp_inc;

  always_comb begin
    set_point = fsic_pkg::set_point_rom(sp_idx_q);

    // restoring divide, one quotient bit per step
    trial = {rem_q, quo_q[DW-1]};
    ge    = (trial >= {1'b0, diff_q});

    if ((|quo_q[DW-1:SW]) || (&quo_q[SW-1:0])) begin
      speed_sat = '1;
    end else begin
      speed_sat = quo_q[SW-1:0] + SW'(1);
    end
    err_nxt  = $signed({1'b0, SW'(set_point)}) - $signed({1'b0, speed_sat});
    prod_nxt = $signed({1'b0, gain_i}) * err_q;

    sum = $signed({{(AW - IB){1'b0}}, integ_q}) + AW'(prod_q);
    if (sum[AW-1]) begin
      integ_nxt = '0;
    end else if (|sum[AW-2:IB]) begin
      integ_nxt = '1;
    end else begin
      integ_nxt = sum[IB-1:0];
    end

    sp_inc = {1'b0, sp_idx_q} + (fsic_pkg::SP_IDX_W + 1)'(1);

    status_o.button   = button_q;
    status_o.fault    = (diff_q == '0);
    status_o.div_more = (cnt_q != fsic_pkg::DIV_CNT_W'(1));

    pulse_width_o   = integ_q[IB-1 -: fsic_pkg::PULSE_W];
    speed_rpm_o     = speed_q;
    set_point_rpm_o = set_point;
    period_fault_o  = fault_q;
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      button_q <= func_i;
      cycles_q <= num_cycles_i;
      diff_q   <= first_capture_i - last_capture_i;
    end
    case (ctrl_i.op)
      fsic_pkg::OP_INIT: begin
        quo_q <= DW'(scale_i) * DW'(cycles_q);
        rem_q <= '0;
        cnt_q <= fsic_pkg::DIV_CNT_W'(DW);
      end
      fsic_pkg::OP_DIV: begin
        quo_q <= {quo_q[DW-2:0], ge};
        rem_q <= ge ? CW'(trial - {1'b0, diff_q}) : trial[CW-1:0];
        cnt_q <= cnt_q - fsic_pkg::DIV_CNT_W'(1);
      end
      fsic_pkg::OP_SPEED: begin
        err_q <= err_nxt;
      end
      fsic_pkg::OP_GAIN: begin
        prod_q <= prod_nxt;
      end
      default: begin
      end
    endcase
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q  <= 1'b0;
      speed_q  <= '0;
      integ_q  <= fsic_pkg::INTEG_RESET;
      sp_idx_q <= fsic_pkg::SP_IDX_RESET;
    end else begin
      if (load_i) begin
        fault_q <= 1'b0;
      end
      case (ctrl_i.op)
        fsic_pkg::OP_SPEED:   speed_q <= speed_sat;
        fsic_pkg::OP_ACCUM:   integ_q <= integ_nxt;
        fsic_pkg::OP_FAULT:   fault_q <= 1'b1;
        fsic_pkg::OP_NEXT_SP: begin
          if (sp_inc >= (fsic_pkg::SP_IDX_W + 1)'(fsic_pkg::SET_POINT_COUNT)) begin
            sp_idx_q <= '0;
          end else begin
            sp_idx_q <= sp_inc[fsic_pkg::SP_IDX_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/fan_speed_integral_control.sv =====
// ============================================================================
// fan_speed_integral_control - closed-loop fan speed controller
// Turns tach measurements into RPM and drives a clamped integral loop
// whose top bits set the PWM pulse width.
// ============================================================================
// Each input transfer yields exactly one output transfer. A tach item
// (tuser = 0) computes speed = tach_scale * num_cycles / capture_difference
// + 1, saturated at 65535, and adds integral_gain * (set point - speed) to a
// 24-bit integrator clamped to its range; a zero capture difference sets
// period_fault and leaves the loop state alone. A button item (tuser = 1)
// steps to the next of twelve set points, wrapping to the first. The input
// is ready again only once an item is through: a tach item runs the 34-step
// restoring divider, one quotient bit per cycle, while a faulted tach item
// and a button item skip it. The result sits in an output register, so the
// next item can be accepted while a result waits; the block only stalls at
// the end of an item if the previous result has not yet been taken.
// Configuration writes are registered and must be made while the block is
// idle.
// ============================================================================
module fan_speed_integral_control (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [6:0] num_cycles, [22:7] first_capture, [38:23] last_capture, [39] zero
  input  logic [fsic_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] func (0 tach measurement, 1 button press)
  input  logic                                s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] pulse_width, [23:8] speed_rpm, [36:24] set_point_rpm,
  // [37] period_fault, [39:38] zero
  output logic [fsic_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [fsic_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [fsic_pkg::CFG_W-1:0]          cfg_wdata_i
);

  logic [fsic_pkg::GAIN_W-1:0]  gain_q;
  logic [fsic_pkg::SCALE_W-1:0] scale_q;

  logic                  idle;
  logic                  start;
  logic                  out_busy;
  fsic_pkg::dp_ctrl_t    ctrl;
  fsic_pkg::dp_status_t  status;

  logic [fsic_pkg::PULSE_W-1:0] pulse_width;
  logic [fsic_pkg::SPEED_W-1:0] speed_rpm;
  logic [fsic_pkg::SP_W-1:0]    set_point_rpm;
  logic                         period_fault;

  logic                              m_valid_q;
  logic [fsic_pkg::OUT_DATA_W-1:0]   m_data_q;

  // Accept a new item only while the sequencer waits at its first step
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;

  // Hold at the done step while the previous result is still pending
  assign out_busy = m_valid_q && !m_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= fsic_pkg::GAIN_RESET;
      scale_q <= fsic_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        fsic_pkg::CFG_GAIN:  gain_q  <= cfg_wdata_i[fsic_pkg::GAIN_W-1:0];
        fsic_pkg::CFG_SCALE: scale_q <= cfg_wdata_i[fsic_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fsic_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_busy_i (out_busy),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .idle_o     (idle)
  );

  fsic_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .load_i          (start),
    .func_i          (s_axis_tuser),
    .num_cycles_i    (s_axis_tdata[6:0]),
    .first_capture_i (s_axis_tdata[22:7]),
    .last_capture_i  (s_axis_tdata[38:23]),
    .gain_i          (gain_q),
    .scale_i         (scale_q),
    .status_o        (status),
    .pulse_width_o   (pulse_width),
    .speed_rpm_o     (speed_rpm),
    .set_point_rpm_o (set_point_rpm),
    .period_fault_o  (period_fault)
  );

  // Output register: load on emit, drop once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      m_data_q <= {2'b00, period_fault, set_point_rpm, speed_rpm, pulse_width};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for the fan speed integral controller
// Drives tach and button items over the input stream, predicts every result
// with an independent model of the speed calculation, the clamped integrator
// and the set point stepper, and checks each output transfer field by field.
// Both stream sides idle and stall at random; gain and scale are swept.
// ============================================================================
module tb;
  import fsic_pkg::*;

  localparam int  WATCHDOG_LIMIT = 1000;  // cycles with no transfer on either side
  localparam int  SETTLE_CYCLES  = 6;     // quiet cycles before a register write
  localparam int  TAIL_CYCLES    = 60;    // watch for stray results at the end
  localparam longint INTEG_MAX   = (longint'(1) << INTEGRATOR_BITS) - 1;

  // One input item: func travels in tuser, the rest in tdata
  typedef struct {
    logic             func;
    logic [CYC_W-1:0] cycles;
    logic [CAP_W-1:0] first_cap;
    logic [CAP_W-1:0] last_cap;
  } fan_item_t;

  // One result item as it leaves the output stream
  typedef struct {
    logic [PULSE_W-1:0] pulse;
    logic [SPEED_W-1:0] rpm;
    logic [SP_W-1:0]    target;
    logic               fault;
  } fan_status_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;

  // Controller state as the bench sees it
  logic [GAIN_W-1:0]          loop_gain;
  logic [SCALE_W-1:0]         rpm_scale;
  logic [INTEGRATOR_BITS-1:0] integ_acc;
  logic [SP_IDX_W-1:0]        sp_sel;
  logic [SPEED_W-1:0]         held_rpm;

  int unsigned target_rpm_tbl [SET_POINT_COUNT] =
    '{2000, 3000, 4000, 5000, 6000, 7000, 8000, 7000, 6000, 5000, 4000, 3000};

  fan_status_t expected_status [$];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          src_idle_en  = 1'b0;
  bit          sink_stall_en = 1'b0;

  fan_speed_integral_control dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void reset_controller_state();
    loop_gain = GAIN_RESET;
    rpm_scale = SCALE_RESET;
    integ_acc = INTEG_RESET;
    sp_sel    = SP_IDX_RESET;
    held_rpm  = '0;
  endfunction

  // Advance the controller state by one item and return the status it reports
  function automatic fan_status_t predict_status(fan_item_t it);
    fan_status_t st;
    logic [CAP_W-1:0] span;
    logic [63:0]      rpm;
    longint           err;
    longint           acc;
    st.fault = 1'b0;
    if (it.func) begin
      // step the set point, wrap after the last table entry
      if (int'(sp_sel) + 1 >= SET_POINT_COUNT) sp_sel = '0;
      else sp_sel = sp_sel + 1'b1;
    end else begin
      span = it.first_cap - it.last_cap;  // down counter, modulo 2^16
      if (span == '0) begin
        st.fault = 1'b1;                  // loop state untouched
      end else begin
        rpm = (64'(rpm_scale) * 64'(it.cycles)) / 64'(span) + 64'd1;
        if (rpm > 64'd65535) rpm = 64'd65535;
        held_rpm = rpm[SPEED_W-1:0];
        err = longint'(target_rpm_tbl[sp_sel]) - longint'(rpm);
        acc = longint'(integ_acc) + longint'(loop_gain) * err;
        if (acc < 0) acc = 0;
        else if (acc > INTEG_MAX) acc = INTEG_MAX;
        integ_acc = acc[INTEGRATOR_BITS-1:0];
      end
    end
    st.pulse  = integ_acc[INTEGRATOR_BITS-1 -: PULSE_W];
    st.rpm    = held_rpm;
    st.target = SP_W'(target_rpm_tbl[sp_sel]);
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Present one item and hold it until the transfer; tvalid stays high so a
  // following item can go out back to back
  task automatic send_item(fan_item_t it);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tdata  <= {1'b0, it.last_cap, it.first_cap, it.cycles};
    s_axis_tuser  <= it.func;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_status.push_back(predict_status(it));
  endtask

  // Drop tvalid and hold until every result is back and the block is quiet
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_GAIN) loop_gain = value[GAIN_W-1:0];
    else rpm_scale = value[SCALE_W-1:0];
  endtask

  task automatic set_loop(logic [GAIN_W-1:0] gain, logic [SCALE_W-1:0] scale);
    wait_drained();
    write_reg(CFG_GAIN, CFG_W'(gain));
    write_reg(CFG_SCALE, CFG_W'(scale));
  endtask

  function automatic fan_item_t tach_item(int cyc, int first, int last);
    fan_item_t it;
    it.func      = 1'b0;
    it.cycles    = CYC_W'(cyc);
    it.first_cap = CAP_W'(first);
    it.last_cap  = CAP_W'(last);
    return it;
  endfunction

  // Mostly plausible tach windows near the set point range, plus button
  // presses, faults and fully random fields
  function automatic fan_item_t random_item();
    fan_item_t it;
    int        pick;
    longint    span;
    pick         = $urandom_range(0, 99);
    it.func      = 1'b0;
    it.cycles    = CYC_W'($urandom);
    it.first_cap = CAP_W'($urandom);
    it.last_cap  = CAP_W'($urandom);
    if (pick < 18) begin
      it.func = 1'b1;                        // capture fields are junk
    end else if (pick < 24) begin
      it.last_cap = it.first_cap;            // zero capture difference
    end else if (pick >= 40) begin
      it.cycles = CYC_W'($urandom_range(1, 12));
      span = longint'(rpm_scale) * longint'(it.cycles) /
             longint'($urandom_range(200, 9000));
      span = span + longint'($urandom_range(0, 40)) - 20;
      if (span < 1) span = 1;
      if (span > 65535) span = 65535;
      it.last_cap = it.first_cap - CAP_W'(span);
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes, faults, capture wrap, both integrator clamps and a full
  // lap of the set point table, at reset gain and scale until the upper clamp
  task automatic test_directed();
    fan_item_t it;
    send_item(tach_item(0, 'h1234, 'h1000));    // zero cycles: speed of one
    send_item(tach_item(1, 'hFFFF, 'h0000));    // widest window
    send_item(tach_item(127, 'hFFFF, 'hFFFF));  // fault, all ones
    send_item(tach_item(0, 'h0000, 'h0000));    // fault, all zeros
    send_item(tach_item(127, 'h0010, 'hFFF0));  // wrapped capture, saturates
    send_item(tach_item(127, 'hFFFF, 'h0000));  // saturates, drives clamp at 0
    send_item(tach_item(1, 'h0001, 'h0000));    // one-tick window
    send_item(tach_item(5, 'h9C40, 'h1D4C));
    // full lap of the set points and past the wrap, junk in the other fields
    for (int i = 0; i < 13; i++) begin
      it.func      = 1'b1;
      it.cycles    = (i % 2) ? '1 : '0;
      it.first_cap = (i % 2) ? '1 : '0;
      it.last_cap  = (i % 2) ? '0 : '1;
      send_item(it);
    end
    // upper clamp with the largest gain and a stalled fan
    set_loop(16'hFFFF, SCALE_RESET);
    send_item(tach_item(0, 'h0400, 'h0200));
    send_item(tach_item(0, 'h0400, 'h0200));
    send_item(tach_item(127, 'h8000, 'h7FFF));  // straight back to zero
  endtask

  // Walk through gain and scale settings including both extremes of each
  task automatic test_gain_and_scale();
    logic [GAIN_W-1:0]  gains  [6] = '{16'd0, 16'd65535, 16'd1, 16'd37, 16'd500, GAIN_RESET};
    logic [SCALE_W-1:0] scales [6] = '{SCALE_RESET, 27'h7FFFFFF, 27'd0, 27'd1, 27'd45000000,
                                       SCALE_RESET};
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    for (int p = 0; p < 6; p++) begin
      set_loop(gains[p], scales[p]);
      repeat (20) send_item(random_item());
    end
  endtask

  // Bulk random traffic; idling switches on and off per block of items
  task automatic test_random_traffic();
    for (int blk = 0; blk < 10; blk++) begin
      src_idle_en   = $urandom_range(0, 2) != 0;
      sink_stall_en = $urandom_range(0, 2) != 0;
      repeat (38) send_item(random_item());
      // hold the source once until every result is back
      if (blk == 4) wait_drained();
    end
  endtask

  // Closing stretch at full rate with no idling on either side
  task automatic test_steady_stream();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    repeat (50) send_item(random_item());
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts while enabled
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each output transfer with the oldest prediction; watchdog on
  // cycles in which neither side moves a transfer
  always @(posedge clk_i) begin
    fan_status_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%h",
                   $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("pulse_width", want.pulse, m_axis_tdata[7:0]);
          check_field("speed_rpm", want.rpm, m_axis_tdata[23:8]);
          check_field("set_point_rpm", want.target, m_axis_tdata[36:24]);
          check_field("period_fault", want.fault, m_axis_tdata[37]);
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles, %0d results pending",
                 $time, quiet_cycles, expected_status.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_controller_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_gain_and_scale();
    test_random_traffic();
    test_steady_stream();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
